// ===== src/mrrs_pkg.sv =====
// ----------------------------------------------------------------------------
// mrrs_pkg
// Shared widths, codes and defaults for the multicore round-robin scheduler.
// ----------------------------------------------------------------------------
package mrrs_pkg;

  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned CORE_W     = 2;
  localparam int unsigned TASK_W     = 6;
  localparam int unsigned SLICE_W    = 16;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned ACT_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SLICE_REGS = 4;

  localparam int unsigned DEF_NUM_CORES   = 4;
  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned DEF_MAX_TASKS   = 63;

  localparam logic [FUNC_W-1:0] FN_LOAD    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_UNBLOCK = 3'd1;
  localparam logic [FUNC_W-1:0] FN_EXIT    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_BLOCK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_TICK    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE3 = 3'd4;

  localparam logic [TASK_W-1:0]  NO_TASK     = 6'd63;
  localparam logic [CNT_W-1:0]   CNT_MAX     = 7'd127;
  localparam logic [ACT_W-1:0]   RST_ACTIVE  = 3'd4;
  localparam logic [SLICE_W-1:0] RST_SLICE   = 16'd10;

endpackage

// ===== src/mrrs_ram.sv =====
// ----------------------------------------------------------------------------
// mrrs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mrrs_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/multicore_round_robin_scheduler.sv =====
// ----------------------------------------------------------------------------
// multicore_round_robin_scheduler
// Round-robin scheduler with one ready queue per core, run by a small
// sequencer that steps one queue or count update per cycle.
// ----------------------------------------------------------------------------
//  channel   | ports                                          | handshake
//  ----------+------------------------------------------------+-----------------
//  request   | func_i core_id_i task_id_i running_task_i      | start_i & !busy_o
//  result    | next_task_o target_core_o queue_overflow_o     | done_o, 1 cycle
//  config    | cfg_idx_i cfg_data_i                           | cfg_we_i
//
//  busy_o stays high while a request steps through a decode state, a push
//  state for a load, unblock or expiring tick, a dispatch state, and a wait
//  state for each ram read (home core on unblock, queue head pop)
//  a load also scans the other active cores, one compare per cycle
//  done_o rises the cycle busy_o falls; a new request may start in that cycle
//  reset clears all counters, heads and fills; the queue and blocked-home
//  rams need no clearing
//  the receiver cannot stall: done_o is a one-cycle strobe
module multicore_round_robin_scheduler #(
  parameter int unsigned NUM_CORES   = mrrs_pkg::DEF_NUM_CORES,
  parameter int unsigned QUEUE_DEPTH = mrrs_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned MAX_TASKS   = mrrs_pkg::DEF_MAX_TASKS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [mrrs_pkg::FUNC_W-1:0]     func_i,
  input  logic [mrrs_pkg::CORE_W-1:0]     core_id_i,
  input  logic [mrrs_pkg::TASK_W-1:0]     task_id_i,
  input  logic [mrrs_pkg::TASK_W-1:0]     running_task_i,
  output logic                            done_o,
  output logic [mrrs_pkg::TASK_W-1:0]     next_task_o,
  output logic [mrrs_pkg::CORE_W-1:0]     target_core_o,
  output logic                            queue_overflow_o,
  input  logic                            cfg_we_i,
  input  logic [mrrs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mrrs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CIDX_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int unsigned HEAD_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W  = $clog2(2 * QUEUE_DEPTH);
  localparam int unsigned QMEM_D = NUM_CORES * QUEUE_DEPTH;
  localparam int unsigned QA_W   = $clog2(QMEM_D);
  localparam int unsigned BH_D   = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_BH_WAIT,
    ST_PUSH,
    ST_DISPATCH,
    ST_RD_WAIT
  } state_e;

  state_e state_q;

  logic [mrrs_pkg::FUNC_W-1:0] func_q;
  logic [mrrs_pkg::CORE_W-1:0] core_q;
  logic [mrrs_pkg::TASK_W-1:0] task_q;
  logic [mrrs_pkg::TASK_W-1:0] run_q;
  logic [mrrs_pkg::TASK_W-1:0] push_task_q;
  logic [CIDX_W-1:0]           core_sel_q;
  logic [mrrs_pkg::ACT_W-1:0]  scan_q;
  logic [mrrs_pkg::CNT_W-1:0]  best_cnt_q;

  logic [HEAD_W-1:0]            head_q  [NUM_CORES];
  logic [FILL_W-1:0]            fill_q  [NUM_CORES];
  logic [mrrs_pkg::SLICE_W-1:0] left_q  [NUM_CORES];
  logic [mrrs_pkg::CNT_W-1:0]   tasks_q [NUM_CORES];

  logic [mrrs_pkg::ACT_W-1:0]   active_q;
  logic [mrrs_pkg::SLICE_W-1:0] slice_cfg_q [mrrs_pkg::SLICE_REGS];

  logic                         done_q;
  logic [mrrs_pkg::TASK_W-1:0]  next_q;
  logic [mrrs_pkg::CORE_W-1:0]  target_q;
  logic                         ovf_q;

  // shared datapath
  logic [CIDX_W-1:0]            ci;
  logic [mrrs_pkg::ACT_W-1:0]   n_act;
  logic [HEAD_W-1:0]            head_cur;
  logic [FILL_W-1:0]            fill_cur;
  logic [SUM_W-1:0]             slot_sum;
  logic [HEAD_W-1:0]            slot;
  logic [HEAD_W-1:0]            head_inc;
  logic [QA_W-1:0]              push_addr;
  logic [QA_W-1:0]              pop_addr;
  logic [mrrs_pkg::SLICE_W-1:0] eff_slice;
  logic [mrrs_pkg::SLICE_W-1:0] left_dec;
  logic                         is_enq;
  logic                         core_ok;
  logic                         queue_full;
  logic                         push_ok;
  logic                         q_we;
  logic                         bh_we;
  logic [mrrs_pkg::TASK_W-1:0]  q_rdata;
  logic [mrrs_pkg::CORE_W-1:0]  bh_rdata;
  logic [mrrs_pkg::CORE_W-1:0]  bh_core;

  always_comb begin
    ci = (state_q == ST_SEARCH) ? scan_q[CIDX_W-1:0] : core_sel_q;

    if (active_q == '0) begin
      n_act = mrrs_pkg::ACT_W'(1);
    end else if (active_q > mrrs_pkg::ACT_W'(NUM_CORES)) begin
      n_act = mrrs_pkg::ACT_W'(NUM_CORES);
    end else begin
      n_act = active_q;
    end

    head_cur   = head_q[ci];
    fill_cur   = fill_q[ci];
    queue_full = (fill_cur == FILL_W'(QUEUE_DEPTH));

    slot_sum = SUM_W'(head_cur) + SUM_W'(fill_cur);
    if (slot_sum >= SUM_W'(QUEUE_DEPTH)) begin
      slot = HEAD_W'(slot_sum - SUM_W'(QUEUE_DEPTH));
    end else begin
      slot = HEAD_W'(slot_sum);
    end

    if (head_cur == HEAD_W'(QUEUE_DEPTH - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = head_cur + HEAD_W'(1);
    end

    push_addr = QA_W'(ci) * QA_W'(QUEUE_DEPTH) + QA_W'(slot);
    pop_addr  = QA_W'(ci) * QA_W'(QUEUE_DEPTH) + QA_W'(head_cur);

    eff_slice = slice_cfg_q[mrrs_pkg::CORE_W'(ci)];
    if (eff_slice == '0) begin
      eff_slice = mrrs_pkg::SLICE_W'(1);
    end
    left_dec = ((left_q[ci] == '0) ? eff_slice : left_q[ci]) - mrrs_pkg::SLICE_W'(1);

    is_enq  = (func_q == mrrs_pkg::FN_LOAD) || (func_q == mrrs_pkg::FN_UNBLOCK);
    core_ok = ({1'b0, core_q} < (mrrs_pkg::CORE_W + 1)'(NUM_CORES));
    push_ok = !(is_enq && (task_q >= mrrs_pkg::TASK_W'(MAX_TASKS))) && !queue_full;

    q_we  = (state_q == ST_PUSH) && push_ok;
    bh_we = (state_q == ST_EXEC) && (func_q == mrrs_pkg::FN_BLOCK) && core_ok &&
            (run_q < mrrs_pkg::TASK_W'(MAX_TASKS));

    bh_core = ({1'b0, bh_rdata} >= (mrrs_pkg::CORE_W + 1)'(NUM_CORES)) ? '0 : bh_rdata;
  end

  mrrs_ram #(
    .WIDTH (mrrs_pkg::TASK_W),
    .DEPTH (QMEM_D),
    .ADDR_W(QA_W)
  ) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (q_we),
    .waddr_i(push_addr),
    .wdata_i(push_task_q),
    .raddr_i(pop_addr),
    .rdata_o(q_rdata)
  );

  mrrs_ram #(
    .WIDTH (mrrs_pkg::CORE_W),
    .DEPTH (BH_D),
    .ADDR_W(mrrs_pkg::TASK_W)
  ) u_home_ram (
    .clk_i  (clk_i),
    .we_i   (bh_we),
    .waddr_i(run_q),
    .wdata_i(core_q),
    .raddr_i(task_q),
    .rdata_o(bh_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= mrrs_pkg::RST_ACTIVE;
      for (int i = 0; i < int'(mrrs_pkg::SLICE_REGS); i++) begin
        slice_cfg_q[i] <= mrrs_pkg::RST_SLICE;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mrrs_pkg::CFG_ACTIVE: active_q       <= cfg_data_i[mrrs_pkg::ACT_W-1:0];
        mrrs_pkg::CFG_SLICE0: slice_cfg_q[0] <= cfg_data_i;
        mrrs_pkg::CFG_SLICE1: slice_cfg_q[1] <= cfg_data_i;
        mrrs_pkg::CFG_SLICE2: slice_cfg_q[2] <= cfg_data_i;
        mrrs_pkg::CFG_SLICE3: slice_cfg_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      done_q      <= 1'b0;
      func_q      <= '0;
      core_q      <= '0;
      task_q      <= '0;
      run_q       <= '0;
      push_task_q <= '0;
      core_sel_q  <= '0;
      scan_q      <= '0;
      best_cnt_q  <= '0;
      next_q      <= mrrs_pkg::NO_TASK;
      target_q    <= '0;
      ovf_q       <= 1'b0;
      for (int i = 0; i < int'(NUM_CORES); i++) begin
        head_q[i]  <= '0;
        fill_q[i]  <= '0;
        left_q[i]  <= '0;
        tasks_q[i] <= '0;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            func_q      <= func_i;
            core_q      <= core_id_i;
            task_q      <= task_id_i;
            run_q       <= running_task_i;
            push_task_q <= task_id_i;
            core_sel_q  <= (func_i == mrrs_pkg::FN_LOAD) ? '0 : core_id_i[CIDX_W-1:0];
            next_q      <= mrrs_pkg::NO_TASK;
            target_q    <= '0;
            ovf_q       <= 1'b0;
            state_q     <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (func_q)
            mrrs_pkg::FN_LOAD: begin
              best_cnt_q <= tasks_q[ci];
              scan_q     <= mrrs_pkg::ACT_W'(1);
              state_q    <= (n_act == mrrs_pkg::ACT_W'(1)) ? ST_PUSH : ST_SEARCH;
            end
            mrrs_pkg::FN_UNBLOCK: begin
              state_q <= ST_BH_WAIT;
            end
            mrrs_pkg::FN_EXIT: begin
              if (!core_ok) begin
                done_q  <= 1'b1;
                state_q <= ST_IDLE;
              end else begin
                if (tasks_q[ci] != '0) begin
                  tasks_q[ci] <= tasks_q[ci] - mrrs_pkg::CNT_W'(1);
                end
                state_q <= ST_DISPATCH;
              end
            end
            mrrs_pkg::FN_BLOCK: begin
              if (!core_ok) begin
                done_q  <= 1'b1;
                state_q <= ST_IDLE;
              end else begin
                state_q <= ST_DISPATCH;
              end
            end
            mrrs_pkg::FN_TICK: begin
              if (!core_ok) begin
                done_q  <= 1'b1;
                state_q <= ST_IDLE;
              end else if (run_q == mrrs_pkg::NO_TASK) begin
                if (fill_cur != '0) begin
                  state_q <= ST_DISPATCH;
                end else begin
                  done_q  <= 1'b1;
                  state_q <= ST_IDLE;
                end
              end else if (left_dec == '0) begin
                push_task_q <= run_q;
                state_q     <= ST_PUSH;
              end else begin
                left_q[ci] <= left_dec;
                next_q     <= run_q;
                done_q     <= 1'b1;
                state_q    <= ST_IDLE;
              end
            end
            default: begin
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end
          endcase
        end
        ST_SEARCH: begin
          if (tasks_q[ci] < best_cnt_q) begin
            best_cnt_q <= tasks_q[ci];
            core_sel_q <= ci;
          end
          if (scan_q == n_act - mrrs_pkg::ACT_W'(1)) begin
            state_q <= ST_PUSH;
          end else begin
            scan_q <= scan_q + mrrs_pkg::ACT_W'(1);
          end
        end
        ST_BH_WAIT: begin
          core_sel_q <= bh_core[CIDX_W-1:0];
          state_q    <= ST_PUSH;
        end
        ST_PUSH: begin
          if (is_enq) begin
            target_q <= mrrs_pkg::CORE_W'(ci);
          end
          if (push_ok) begin
            fill_q[ci] <= fill_cur + FILL_W'(1);
            if ((func_q == mrrs_pkg::FN_LOAD) && (tasks_q[ci] != mrrs_pkg::CNT_MAX)) begin
              tasks_q[ci] <= tasks_q[ci] + mrrs_pkg::CNT_W'(1);
            end
          end else if (!(is_enq && (task_q >= mrrs_pkg::TASK_W'(MAX_TASKS)))) begin
            ovf_q <= 1'b1;
          end
          if (is_enq) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          left_q[ci] <= eff_slice;
          if (fill_cur != '0) begin
            head_q[ci] <= head_inc;
            fill_q[ci] <= fill_cur - FILL_W'(1);
            state_q    <= ST_RD_WAIT;
          end else begin
            next_q  <= mrrs_pkg::NO_TASK;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        ST_RD_WAIT: begin
          next_q  <= q_rdata;
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign next_task_o      = next_q;
  assign target_core_o    = target_q;
  assign queue_overflow_o = ovf_q;

endmodule

// ===== bench/sched_checker.sv =====
// ----------------------------------------------------------------------------
// sched_checker
// Watches the request, result and register ports of the round-robin
// scheduler, keeps its own copy of the ready queues, slices and per-core task
// counts, and compares every result strobe field by field with the pick that
// this copy predicts for the oldest open request.
// ----------------------------------------------------------------------------
module sched_checker
  import mrrs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [CORE_W-1:0]     core_id_i,
  input  logic [TASK_W-1:0]     task_id_i,
  input  logic [TASK_W-1:0]     running_task_i,
  input  logic                  done_i,
  input  logic [TASK_W-1:0]     next_task_i,
  input  logic [CORE_W-1:0]     target_core_i,
  input  logic                  queue_overflow_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NCORES = DEF_NUM_CORES;
  localparam int unsigned QDEPTH = DEF_QUEUE_DEPTH;

  typedef struct packed {
    logic [TASK_W-1:0] next_task;
    logic [CORE_W-1:0] target_core;
    logic              overflow;
  } pick_t;

  pick_t expected_picks [$];
  pick_t got_pick;
  pick_t want_pick;
  int unsigned mismatches = 0;

  logic [ACT_W-1:0]   active_cfg;
  logic [SLICE_W-1:0] slice_cfg  [SLICE_REGS];
  logic [TASK_W-1:0]  ready_ring [NCORES][QDEPTH];
  logic [3:0]         q_head     [NCORES];
  logic [4:0]         q_fill     [NCORES];
  logic [SLICE_W-1:0] slice_left [NCORES];
  logic [CNT_W-1:0]   core_load  [NCORES];
  logic [CORE_W-1:0]  home_core  [64];

  function automatic logic [SLICE_W-1:0] slice_len(int c);
    return (slice_cfg[c] == '0) ? SLICE_W'(1) : slice_cfg[c];
  endfunction

  function automatic logic enqueue_task(int c, logic [TASK_W-1:0] t);
    if (q_fill[c] >= QDEPTH) return 1'b0;
    ready_ring[c][4'(q_head[c] + q_fill[c])] = t;
    q_fill[c]++;
    return 1'b1;
  endfunction

  function automatic logic [TASK_W-1:0] dispatch_head(int c);
    logic [TASK_W-1:0] t;
    t = NO_TASK;
    if (q_fill[c] != '0) begin
      t = ready_ring[c][q_head[c]];
      q_head[c] = q_head[c] + 4'd1;
      q_fill[c]--;
    end
    slice_left[c] = slice_len(c);
    return t;
  endfunction

  task automatic flag_mismatch(string field, int unsigned want, int unsigned got);
    mismatches++;
    $display("mismatch at %0t ns: %s expected %0d, got %0d", $time, field, want, got);
  endtask

  // one request in, one predicted pick out
  task automatic schedule_event(logic [FUNC_W-1:0] fn, logic [CORE_W-1:0] cr,
                                logic [TASK_W-1:0] tk, logic [TASK_W-1:0] rn);
    pick_t r;
    int c;
    int act;
    logic [SLICE_W-1:0] lft;
    r = '{next_task: NO_TASK, target_core: '0, overflow: 1'b0};
    case (fn)
      FN_LOAD, FN_UNBLOCK: begin
        if (fn == FN_LOAD) begin
          act = (active_cfg == '0) ? 1 : (active_cfg > NCORES) ? NCORES : active_cfg;
          c = 0;
          for (int i = 1; i < act; i++) if (core_load[i] < core_load[c]) c = i;
        end else begin
          c = home_core[tk];
        end
        r.target_core = CORE_W'(c);
        if (tk < DEF_MAX_TASKS) begin
          if (enqueue_task(c, tk)) begin
            if (fn == FN_LOAD && core_load[c] != CNT_MAX) core_load[c]++;
          end else begin
            r.overflow = 1'b1;
          end
        end
      end
      FN_EXIT: begin
        if (core_load[cr] != '0) core_load[cr]--;
        r.next_task = dispatch_head(cr);
      end
      FN_BLOCK: begin
        if (rn < DEF_MAX_TASKS) home_core[rn] = cr;
        r.next_task = dispatch_head(cr);
      end
      FN_TICK: begin
        if (rn == NO_TASK) begin
          if (q_fill[cr] != '0) r.next_task = dispatch_head(cr);
        end else begin
          lft = (slice_left[cr] == '0) ? slice_len(cr) : slice_left[cr];
          lft--;
          if (lft == '0) begin
            if (!enqueue_task(cr, rn)) r.overflow = 1'b1;
            r.next_task = dispatch_head(cr);
          end else begin
            slice_left[cr] = lft;
            r.next_task = rn;
          end
        end
      end
      default: ;
    endcase
    expected_picks = {expected_picks, r};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_cfg = RST_ACTIVE;
      for (int i = 0; i < SLICE_REGS; i++) slice_cfg[i] = RST_SLICE;
      for (int i = 0; i < NCORES; i++) begin
        q_head[i]     = '0;
        q_fill[i]     = '0;
        slice_left[i] = '0;
        core_load[i]  = '0;
      end
      for (int i = 0; i < 64; i++) home_core[i] = '0;
      expected_picks.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ACTIVE) active_cfg = cfg_data_i[ACT_W-1:0];
        else if (cfg_idx_i >= CFG_SLICE0 && cfg_idx_i <= CFG_SLICE3)
          slice_cfg[cfg_idx_i - CFG_SLICE0] = cfg_data_i;
      end
      // the result of the previous request comes before a request taken at the same edge
      if (done_i) begin
        got_pick = '{next_task: next_task_i, target_core: target_core_i,
                     overflow: queue_overflow_i};
        if (expected_picks.size() == 0) begin
          flag_mismatch("unexpected result, next_task", NO_TASK, got_pick.next_task);
        end else begin
          want_pick = expected_picks.pop_front();
          if (got_pick.next_task != want_pick.next_task)
            flag_mismatch("next_task", want_pick.next_task, got_pick.next_task);
          if (got_pick.target_core != want_pick.target_core)
            flag_mismatch("target_core", want_pick.target_core, got_pick.target_core);
          if (got_pick.overflow != want_pick.overflow)
            flag_mismatch("queue_overflow", want_pick.overflow, got_pick.overflow);
        end
      end
      if (start_i && !busy_i) schedule_event(func_i, core_id_i, task_id_i, running_task_i);
      pending_o    <= expected_picks.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the multicore round-robin scheduler: a directed pass over every
// event kind and corner, then random event streams under several register
// settings, including a run that drives a core's task count into saturation.
// Results are checked by sched_checker.
// ----------------------------------------------------------------------------
module tb;
  import mrrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 7;
  localparam int unsigned PHASE_ITEMS = 38;
  localparam int unsigned SAT_PAIRS   = 132;
  localparam logic [FUNC_W-1:0] FN_SPARE_LO  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_MID = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI  = 3'd7;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [FUNC_W-1:0]     func = '0;
  logic [CORE_W-1:0]     core_id = '0;
  logic [TASK_W-1:0]     task_id = '0;
  logic [TASK_W-1:0]     running_task = '0;
  logic                  done;
  logic [TASK_W-1:0]     next_task;
  logic [CORE_W-1:0]     target_core;
  logic                  queue_overflow;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int unsigned           fail_count;
  int unsigned           pending;

  int unsigned cycles = 0;
  int unsigned sent_by_func [8];
  int unsigned settings_applied = 0;
  bit          gaps_on = 1'b1;
  bit          homed [64];
  int          homed_list [$];

  logic [TASK_W-1:0] on_core [DEF_NUM_CORES];
  logic [CORE_W-1:0] inflight_core;
  logic              inflight_sched;

  logic [ACT_W-1:0]   act_plan   [PHASES] = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd5, 3'd3, 3'd4};
  logic [SLICE_W-1:0] slice_plan [PHASES][SLICE_REGS] = '{
    '{16'd1, 16'd1,     16'd1,     16'd1},
    '{16'd0, 16'd65535, 16'd2,     16'd3},
    '{16'd3, 16'd0,     16'd65535, 16'd1},
    '{16'd2, 16'd5,     16'd4,     16'd3},
    '{16'd4, 16'd2,     16'd3,     16'd65535},
    '{16'd6, 16'd1,     16'd2,     16'd2},
    '{16'd3, 16'd3,     16'd3,     16'd3}
  };

  multicore_round_robin_scheduler DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_o           (busy),
    .func_i           (func),
    .core_id_i        (core_id),
    .task_id_i        (task_id),
    .running_task_i   (running_task),
    .done_o           (done),
    .next_task_o      (next_task),
    .target_core_o    (target_core),
    .queue_overflow_o (queue_overflow),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data)
  );

  sched_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .func_i           (func),
    .core_id_i        (core_id),
    .task_id_i        (task_id),
    .running_task_i   (running_task),
    .done_i           (done),
    .next_task_i      (next_task),
    .target_core_i    (target_core),
    .queue_overflow_i (queue_overflow),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // track what each core runs so ticks mostly name the real running task
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      for (int i = 0; i < DEF_NUM_CORES; i++) on_core[i] <= NO_TASK;
      inflight_core  <= '0;
      inflight_sched <= 1'b0;
    end else begin
      if (done && inflight_sched) on_core[inflight_core] <= next_task;
      if (start && !busy) begin
        inflight_core  <= core_id;
        inflight_sched <= func inside {FN_EXIT, FN_BLOCK, FN_TICK};
      end
    end
  end

  task automatic issue(logic [FUNC_W-1:0] fn, logic [CORE_W-1:0] cr,
                       logic [TASK_W-1:0] tk, logic [TASK_W-1:0] rn);
    if (gaps_on && $urandom_range(99) < 33) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start        <= 1'b1;
    func         <= fn;
    core_id      <= cr;
    task_id      <= tk;
    running_task <= rn;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_by_func[fn]++;
    if (fn == FN_BLOCK && rn < DEF_MAX_TASKS && !homed[rn]) begin
      homed[rn] = 1'b1;
      homed_list = {homed_list, int'(rn)};
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned r;
    logic [CORE_W-1:0] cr;
    logic [TASK_W-1:0] rn;
    pick = $urandom_range(99);
    cr   = CORE_W'($urandom_range(DEF_NUM_CORES - 1));
    r    = $urandom_range(9);
    rn   = (r < 7) ? on_core[cr] : (r < 8) ? NO_TASK : TASK_W'($urandom_range(63));
    if (pick < 25)
      issue(FN_LOAD, cr, ($urandom_range(19) == 0) ? NO_TASK
                                                   : TASK_W'($urandom_range(62)), rn);
    else if (pick < 35 && homed_list.size() != 0)
      issue(FN_UNBLOCK, cr, homed_list[$urandom_range(homed_list.size() - 1)], rn);
    else if (pick < 48)
      issue(FN_EXIT, cr, TASK_W'($urandom_range(63)), rn);
    else if (pick < 62)
      issue(FN_BLOCK, cr, TASK_W'($urandom_range(63)), rn);
    else if (pick < 95)
      issue(FN_TICK, cr, TASK_W'($urandom_range(63)), rn);
    else
      issue(FUNC_W'($urandom_range(FN_SPARE_HI, FN_SPARE_LO)), cr,
            TASK_W'($urandom_range(63)), TASK_W'($urandom_range(63)));
    if ($urandom_range(99) < 3) settle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass under reset settings
    issue(FN_EXIT,    2'd0, 6'd0,      NO_TASK);
    issue(FN_TICK,    2'd1, 6'd0,      NO_TASK);
    issue(FN_BLOCK,   2'd2, 6'd0,      NO_TASK);
    issue(FN_LOAD,    2'd0, 6'd0,      6'd0);
    issue(FN_LOAD,    2'd0, 6'd62,     6'd0);
    issue(FN_LOAD,    2'd0, NO_TASK,   6'd0);
    issue(FN_LOAD,    2'd0, 6'd33,     6'd0);
    issue(FN_LOAD,    2'd0, 6'd21,     6'd0);
    issue(FN_TICK,    2'd0, 6'd0,      NO_TASK);
    issue(FN_TICK,    2'd0, 6'd0,      6'd0);
    issue(FN_BLOCK,   2'd0, 6'd0,      6'd0);
    issue(FN_UNBLOCK, 2'd0, 6'd0,      6'd0);
    issue(FN_EXIT,    2'd1, 6'd0,      6'd62);
    issue(FN_TICK,    2'd3, 6'd0,      6'd42);
    issue(FN_SPARE_LO, 2'd0, 6'd0,     6'd0);
    issue(FN_SPARE_MID, 2'd1, 6'd42,   6'd21);
    issue(FN_SPARE_HI, 2'd3, NO_TASK,  NO_TASK);
    issue(FN_BLOCK,   2'd3, 6'd0,      6'd62);
    issue(FN_UNBLOCK, 2'd1, 6'd62,     6'd0);
    issue(FN_TICK,    2'd2, 6'd0,      NO_TASK);
    issue(FN_EXIT,    2'd3, 6'd0,      6'd21);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      set_reg(CFG_ACTIVE, CFG_DATA_W'(act_plan[p]));
      for (int s = 0; s < SLICE_REGS; s++)
        set_reg(CFG_IDX_W'(CFG_SLICE0 + s), slice_plan[p][s]);
      cfg_we <= 1'b0;
      settings_applied++;
      gaps_on = (p != 3);
      for (int i = 0; i < PHASE_ITEMS; i++) random_item();
      // single active core: loads and idle pickups push core 0 into saturation
      if (p == 0) begin
        gaps_on = 1'b0;
        for (int i = 0; i < SAT_PAIRS; i++) begin
          issue(FN_LOAD, 2'd0, TASK_W'($urandom_range(62)), NO_TASK);
          issue(FN_TICK, 2'd0, 6'd0, NO_TASK);
        end
      end
      settle();
    end

    repeat (8) @(posedge clk);
    $display("sent %0d load, %0d unblock, %0d exit, %0d block, %0d tick, %0d unused-code requests",
             sent_by_func[FN_LOAD], sent_by_func[FN_UNBLOCK], sent_by_func[FN_EXIT],
             sent_by_func[FN_BLOCK], sent_by_func[FN_TICK],
             sent_by_func[FN_SPARE_LO] + sent_by_func[FN_SPARE_MID] +
             sent_by_func[FN_SPARE_HI]);
    $display("%0d register settings exercised, %0d mismatches", settings_applied, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
